// ----- hw/rtl/ptdm_pkg.sv -----
// Shared constants, codes and helpers for the pen travel distance meter.
package ptdm_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int ACC_BITS   = 48;

   // Fixed port widths
   localparam int WORD_W = 16;
   localparam int POS_W  = 16;
   localparam int LEN_W  = 25;
   localparam int KIND_W = 2;

   // Derived datapath widths
   localparam int SUM_BITS  = 2 * COORD_BITS + 1;
   localparam int ROOT_BITS = COORD_BITS + 1 + FRAC_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int SQ_CNT_W  = $clog2(COORD_BITS);
   localparam int RT_CNT_W  = $clog2(ROOT_BITS);

   // Command words
   localparam logic [WORD_W-1:0] CMD_PEN_DOWN = 16'h8FDD;
   localparam logic [WORD_W-1:0] CMD_PEN_UP   = 16'h8FEE;
   localparam logic [WORD_W-1:0] CMD_SEL_LO   = 16'h8FF1;
   localparam logic [WORD_W-1:0] CMD_SEL_HI   = 16'h8FF7;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_MOVE     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PEN_DOWN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEN_UP   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_PEN_SEL  = 2'd3;

   typedef logic [ACC_BITS-1:0] acc_type;

   function automatic acc_type sat_add(input acc_type a, input acc_type b);
      logic [ACC_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[ACC_BITS] ? '1 : s[ACC_BITS-1:0];
   endfunction

endpackage

// ----- hw/rtl/ptdm_sqmul.sv -----
// Bit-serial dx*dx + dy*dy, one multiplier bit of each square per cycle.
module ptdm_sqmul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ptdm_pkg::COORD_BITS-1:0] dx,
   input  logic [ptdm_pkg::COORD_BITS-1:0] dy,
   output logic                           done,
   output logic [ptdm_pkg::SUM_BITS-1:0]   sum
);
   import ptdm_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [SQ_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [COORD_BITS-1:0]     mx_ff, mx_in, my_ff, my_in;
   logic [2*COORD_BITS-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic [SUM_BITS-1:0]       acc_ff, acc_in;
   logic [SUM_BITS-1:0]       px, py;

   assign px = mx_ff[0] ? SUM_BITS'(ax_ff) : '0;
   assign py = my_ff[0] ? SUM_BITS'(ay_ff) : '0;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mx_in   = dx;
         my_in   = dy;
         ax_in   = (2*COORD_BITS)'(dx);
         ay_in   = (2*COORD_BITS)'(dy);
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + px + py;
         ax_in  = ax_ff << 1;
         ay_in  = ay_ff << 1;
         mx_in  = mx_ff >> 1;
         my_in  = my_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CNT_W'(COORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

// ----- hw/rtl/ptdm_isqrt.sv -----
// Restoring integer square root, one root bit per cycle, radicand scaled by 4^FRAC_BITS.
module ptdm_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ptdm_pkg::SUM_BITS-1:0]   radicand,
   output logic                            done,
   output logic [ptdm_pkg::ROOT_BITS-1:0]  root
);
   import ptdm_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RAD_BITS-1:0]   rad_ff, rad_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [REM_BITS-1:0]   rem_sh, trial;
   logic                  fits;

   // bring down the next radicand bit pair, try (root << 2) | 1
   assign rem_sh = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = RAD_BITS'(radicand) << (2 * FRAC_BITS);
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = fits ? rem_sh - trial : rem_sh;
         root_in = {root_ff[ROOT_BITS-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == RT_CNT_W'(ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- hw/rtl/pen_travel_distance_meter_unit.sv -----
// Pen travel distance meter: command decode, move length and saturating totals.
// From accept to rsp_valid, a move passes through the bit-serial squarer, the one-bit-per-cycle
// root, an accumulate state and the result register; a pen command goes straight to the
// result register. One word is in flight at a time; the next word is taken the cycle
// after the result register loads, which waits while rsp_valid is high and rsp_ready is low.
// Synchronous reset: pen up, position (0,0), both totals zero, no result pending.
module pen_travel_distance_meter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ptdm_pkg::WORD_W-1:0]   req_first_word,
   input  logic [ptdm_pkg::WORD_W-1:0]   req_second_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ptdm_pkg::KIND_W-1:0]   rsp_item_kind,
   output logic                          rsp_pen_is_down,
   output logic [ptdm_pkg::POS_W-1:0]    rsp_pos_x,
   output logic [ptdm_pkg::POS_W-1:0]    rsp_pos_y,
   output logic [ptdm_pkg::LEN_W-1:0]    rsp_step_length,
   output logic [ptdm_pkg::ACC_BITS-1:0] rsp_up_total,
   output logic [ptdm_pkg::ACC_BITS-1:0] rsp_down_total,
   output logic [ptdm_pkg::ACC_BITS-1:0] rsp_sum_total
);
   import ptdm_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_RT   = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  pen_ff, pen_in;
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] nx_ff, nx_in, ny_ff, ny_in;
   acc_type               up_ff, up_in, down_ff, down_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [ROOT_BITS-1:0]  len_ff, len_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     o_kind_ff;
   logic                  o_pen_ff;
   logic [POS_W-1:0]      o_x_ff, o_y_ff;
   logic [LEN_W-1:0]      o_len_ff;
   acc_type               o_up_ff, o_down_ff, o_sum_ff;

   logic                  req_fire, load_out, arg_zero;
   logic                  is_down, is_up, is_sel;
   logic [COORD_BITS-1:0] nx, ny, dx, dy;
   logic                  sq_done, rt_done;
   logic [SUM_BITS-1:0]   sq_sum;
   logic [ROOT_BITS-1:0]  rt_root;
   acc_type               len_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign arg_zero = (req_second_word == '0);
   assign is_down  = (req_first_word == CMD_PEN_DOWN) && arg_zero;
   assign is_up    = (req_first_word == CMD_PEN_UP) && arg_zero;
   assign is_sel   = (req_first_word inside {[CMD_SEL_LO:CMD_SEL_HI]}) && arg_zero;

   assign nx = COORD_BITS'(req_first_word);
   assign ny = COORD_BITS'(req_second_word);
   assign dx = (nx >= cur_x_ff) ? nx - cur_x_ff : cur_x_ff - nx;
   assign dy = (ny >= cur_y_ff) ? ny - cur_y_ff : cur_y_ff - ny;
   assign len_ext = ACC_BITS'(len_ff);

   ptdm_sqmul u_sqmul (
      .clock (clock),
      .reset (reset),
      .start (req_fire && !is_down && !is_up && !is_sel),
      .dx    (dx),
      .dy    (dy),
      .done  (sq_done),
      .sum   (sq_sum)
   );

   ptdm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_done),
      .radicand (sq_sum),
      .done     (rt_done),
      .root     (rt_root)
   );

   always_comb begin
      state_in = state_ff;
      pen_in   = pen_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      up_in    = up_ff;
      down_in  = down_ff;
      kind_in  = kind_ff;
      len_in   = len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               nx_in  = nx;
               ny_in  = ny;
               len_in = '0;
               if (is_down) begin
                  pen_in   = 1'b1;
                  kind_in  = KIND_PEN_DOWN;
                  state_in = ST_DONE;
               end else if (is_up) begin
                  pen_in   = 1'b0;
                  kind_in  = KIND_PEN_UP;
                  state_in = ST_DONE;
               end else if (is_sel) begin
                  kind_in  = KIND_PEN_SEL;
                  state_in = ST_DONE;
               end else begin
                  kind_in  = KIND_MOVE;
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            if (sq_done) state_in = ST_RT;
         end
         ST_RT: begin
            if (rt_done) begin
               len_in   = rt_root;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (pen_ff) down_in = sat_add(down_ff, len_ext);
            else        up_in   = sat_add(up_ff, len_ext);
            cur_x_in = nx_ff;
            cur_y_in = ny_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_ff       <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         up_ff        <= '0;
         down_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_ff       <= pen_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         up_ff        <= up_in;
         down_ff      <= down_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      kind_ff <= kind_in;
      len_ff  <= len_in;
      if (load_out) begin
         o_kind_ff <= kind_ff;
         o_pen_ff  <= pen_ff;
         o_x_ff    <= POS_W'(cur_x_ff);
         o_y_ff    <= POS_W'(cur_y_ff);
         o_len_ff  <= LEN_W'(len_ff);
         o_up_ff   <= up_ff;
         o_down_ff <= down_ff;
         o_sum_ff  <= sat_add(up_ff, down_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item_kind   = o_kind_ff;
   assign rsp_pen_is_down = o_pen_ff;
   assign rsp_pos_x       = o_x_ff;
   assign rsp_pos_y       = o_y_ff;
   assign rsp_step_length = o_len_ff;
   assign rsp_up_total    = o_up_ff;
   assign rsp_down_total  = o_down_ff;
   assign rsp_sum_total   = o_sum_ff;

   a_sq_done_in_sq: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> state_ff == ST_SQ)
      else $error("squarer finished outside its state");

   a_rt_done_in_rt: assert property (@(posedge clock) disable iff (reset)
      rt_done |-> state_ff == ST_RT)
      else $error("root finished outside its state");

   a_cmd_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_kind != KIND_MOVE |-> rsp_step_length == '0)
      else $error("command word carries a nonzero length");

   a_sum_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sum_total >= rsp_up_total && rsp_sum_total >= rsp_down_total)
      else $error("sum total below a component total");

endmodule

// ----- tb/tb_pen_travel_distance_meter_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the pen travel distance meter: directed and random plotter words.
module tb_pen_travel_distance_meter_unit;
   import ptdm_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic [ACC_BITS-1:0] ACC_MAX = '1;
   localparam logic [WORD_W-1:0] CMD_SEL_MID = 16'h8FF5;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic                pen_down;
      logic [POS_W-1:0]    x;
      logic [POS_W-1:0]    y;
      logic [LEN_W-1:0]    len;
      logic [ACC_BITS-1:0] up;
      logic [ACC_BITS-1:0] down;
      logic [ACC_BITS-1:0] sum;
   } travel_report_type;

   logic                clock;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [WORD_W-1:0]   req_first_word  = '0;
   logic [WORD_W-1:0]   req_second_word = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [KIND_W-1:0]   rsp_item_kind;
   logic                rsp_pen_is_down;
   logic [POS_W-1:0]    rsp_pos_x;
   logic [POS_W-1:0]    rsp_pos_y;
   logic [LEN_W-1:0]    rsp_step_length;
   logic [ACC_BITS-1:0] rsp_up_total;
   logic [ACC_BITS-1:0] rsp_down_total;
   logic [ACC_BITS-1:0] rsp_sum_total;

   // Plotter state as the testbench tracks it
   logic                  pen_lowered = 1'b0;
   logic [COORD_BITS-1:0] at_x        = '0;
   logic [COORD_BITS-1:0] at_y        = '0;
   logic [ACC_BITS-1:0]   up_travel   = '0;
   logic [ACC_BITS-1:0]   down_travel = '0;

   travel_report_type pending_travel[$];
   int failures      = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   pen_travel_distance_meter_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_word  (req_first_word),
      .req_second_word (req_second_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_item_kind   (rsp_item_kind),
      .rsp_pen_is_down (rsp_pen_is_down),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_step_length (rsp_step_length),
      .rsp_up_total    (rsp_up_total),
      .rsp_down_total  (rsp_down_total),
      .rsp_sum_total   (rsp_sum_total)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic logic [ACC_BITS-1:0] acc_add(input logic [ACC_BITS-1:0] a,
                                                   input logic [ACC_BITS-1:0] b);
      if (b > ACC_MAX - a)
         return ACC_MAX;
      return a + b;
   endfunction

   // floor(sqrt(d^2 * 4^FRAC_BITS)), settled one root bit at a time from the top
   function automatic logic [LEN_W-1:0] move_length(input logic [COORD_BITS-1:0] ax,
                                                    input logic [COORD_BITS-1:0] ay,
                                                    input logic [COORD_BITS-1:0] bx,
                                                    input logic [COORD_BITS-1:0] by);
      logic [63:0] dx;
      logic [63:0] dy;
      logic [63:0] rad;
      logic [63:0] root;
      logic [63:0] cand;
      dx   = (bx >= ax) ? 64'(bx - ax) : 64'(ax - bx);
      dy   = (by >= ay) ? 64'(by - ay) : 64'(ay - by);
      rad  = (dx * dx + dy * dy) << (2 * FRAC_BITS);
      root = '0;
      for (int b = ROOT_BITS - 1; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= rad)
            root = cand;
      end
      return root[LEN_W-1:0];
   endfunction

   function automatic travel_report_type predict_travel(input logic [WORD_W-1:0] w0,
                                                        input logic [WORD_W-1:0] w1);
      travel_report_type r;
      r.len = '0;
      if (w0 == CMD_PEN_DOWN && w1 == '0) begin
         pen_lowered = 1'b1;
         r.kind      = KIND_PEN_DOWN;
      end else if (w0 == CMD_PEN_UP && w1 == '0) begin
         pen_lowered = 1'b0;
         r.kind      = KIND_PEN_UP;
      end else if (w0 >= CMD_SEL_LO && w0 <= CMD_SEL_HI && w1 == '0) begin
         r.kind = KIND_PEN_SEL;
      end else begin
         r.len = move_length(at_x, at_y, w0[COORD_BITS-1:0], w1[COORD_BITS-1:0]);
         // pen state before the move picks the total
         if (pen_lowered)
            down_travel = acc_add(down_travel, ACC_BITS'(r.len));
         else
            up_travel = acc_add(up_travel, ACC_BITS'(r.len));
         at_x   = w0[COORD_BITS-1:0];
         at_y   = w1[COORD_BITS-1:0];
         r.kind = KIND_MOVE;
      end
      r.pen_down = pen_lowered;
      r.x        = at_x;
      r.y        = at_y;
      r.up       = up_travel;
      r.down     = down_travel;
      r.sum      = acc_add(up_travel, down_travel);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
         failures++;
      end
   endtask

   // result side: random stall, scoreboard, watchdog
   always @(posedge clock) begin
      travel_report_type want;
      if (reset) begin
         rsp_ready    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_travel.size() == 0) begin
               $display("%0t: unexpected result word, kind %h", $realtime, rsp_item_kind);
               failures++;
            end else begin
               want = pending_travel.pop_front();
               check_field("item_kind", want.kind, rsp_item_kind);
               check_field("pen_is_down", want.pen_down, rsp_pen_is_down);
               check_field("pos_x", want.x, rsp_pos_x);
               check_field("pos_y", want.y, rsp_pos_y);
               check_field("step_length", want.len, rsp_step_length);
               check_field("up_total", want.up, rsp_up_total);
               check_field("down_total", want.down, rsp_down_total);
               check_field("sum_total", want.sum, rsp_sum_total);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // valid stays up across back-to-back words; it only drops for an idle gap
   task automatic send_word(input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1);
      bit lowered;
      lowered = 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         if (!lowered)
            req_valid <= 1'b0;
         lowered = 1'b1;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_first_word  <= w0;
      req_second_word <= w1;
      do
         @(posedge clock);
      while (!req_ready);
      pending_travel.insert(pending_travel.size(), predict_travel(w0, w1));
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (pending_travel.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_pen_commands();
      send_word(CMD_PEN_DOWN, 16'h0000);
      send_word(CMD_SEL_LO, 16'h0000);
      send_word(CMD_SEL_MID, 16'h0000);
      send_word(CMD_SEL_HI, 16'h0000);
      send_word(CMD_PEN_DOWN, 16'h0000);
      send_word(CMD_PEN_UP, 16'h0000);
      send_word(CMD_PEN_UP, 16'h0000);
      // near misses and command codes with a nonzero y are moves
      send_word(CMD_SEL_LO - 16'd1, 16'h0000);
      send_word(CMD_SEL_HI + 16'd1, 16'h0000);
      send_word(CMD_PEN_DOWN, 16'h0001);
      send_word(CMD_PEN_UP, 16'h8000);
      send_word(CMD_SEL_LO + 16'd2, 16'hFFFF);
   endtask

   task automatic test_move_extremes();
      send_word(16'h0000, 16'h0000);
      send_word(16'h0000, 16'h0000);
      send_word(16'hFFFF, 16'hFFFF);
      send_word(CMD_PEN_DOWN, 16'h0000);
      send_word(16'h0000, 16'h0000);
      send_word(16'hFFFF, 16'h0000);
      send_word(16'h0000, 16'hFFFF);
      send_word(16'h0000, 16'hFFFF);
      send_word(16'h0001, 16'hFFFE);
      send_word(CMD_SEL_LO, 16'h0000);
      send_word(16'hAAAA, 16'h5555);
      send_word(CMD_PEN_UP, 16'h0000);
      send_word(16'h5555, 16'hAAAA);
   endtask

   task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_words);
      int op;
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      for (int i = 0; i < n_words; i++) begin
         if (i == n_words / 2)
            pause_until_drained();
         op = $urandom_range(99);
         if (op < 12) begin
            w0 = CMD_PEN_DOWN;
            w1 = '0;
         end else if (op < 24) begin
            w0 = CMD_PEN_UP;
            w1 = '0;
         end else if (op < 32) begin
            w0 = WORD_W'($urandom_range(CMD_SEL_HI, CMD_SEL_LO));
            w1 = '0;
         end else if (op < 38) begin
            // command-like words that decode as moves
            case ($urandom_range(3))
               0: begin w0 = CMD_PEN_DOWN;        w1 = WORD_W'($urandom_range(16'hFFFF, 1)); end
               1: begin w0 = CMD_PEN_UP;          w1 = WORD_W'($urandom_range(16'hFFFF, 1)); end
               2: begin w0 = CMD_SEL_LO - 16'd1;  w1 = '0; end
               default: begin w0 = CMD_SEL_HI + 16'd1; w1 = '0; end
            endcase
         end else if (op < 55) begin
            // short hop around the current position, wrapping at the edges
            w0 = at_x + WORD_W'($urandom_range(32)) - 16'd16;
            w1 = at_y + WORD_W'($urandom_range(32)) - 16'd16;
         end else if (op < 60) begin
            w0 = at_x;
            w1 = at_y;
         end else begin
            w0 = WORD_W'($urandom);
            w1 = WORD_W'($urandom);
         end
         send_word(w0, w1);
      end
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (pending_travel.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   endtask

   initial begin
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 14;
      recv_idle_pct = 58;
      test_pen_commands();
      test_move_extremes();
      test_random_traffic(14, 58, 380);
      test_random_traffic(58, 14, 380);
      test_random_traffic(0, 0, 380);
      finish_run();
   end

endmodule
